@@ rtl/hcff_pkg.sv @@
// Shared constants and types of the header checksum frame finder.
package hcff_pkg;

	localparam int PACKET_LEN = 16;
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = $clog2(PACKET_LEN + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SYNC_FIRST  = 2'd0,
		CFG_SYNC_SECOND = 2'd1,
		CFG_NODE_ID     = 2'd2
	} cfg_idx_t;

	// Control of one window cell.
	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctrl_t;

	// Control of one output buffer cell.
	typedef struct packed {
		logic load;
		logic shift;
	} out_ctrl_t;

endpackage

@@ rtl/hcff_if.sv @@
// Valid/ready channel interfaces for received bytes and frame bytes.
interface hcff_rx_if;
	logic                 valid;
	logic                 ready;
	hcff_pkg::byte_t      rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hcff_frame_if;
	logic                 valid;
	logic                 ready;
	hcff_pkg::byte_t      frame_byte;
	logic                 frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

@@ rtl/header_checksum_frame_finder_unit.sv @@
// Top level of the header checksum frame finder.
//
// Usage:
//   rx    : one received byte per item (valid/ready). Bytes enter a chain of
//           PACKET_LEN window cells that shift by one on every accepted item.
//   frame : matched frame bytes, oldest first, frame_last on the final one.
//   cfg   : write sync_first (0), sync_second (1), node_id (2) while idle.
// A frame matches when the window is full, its first two bytes equal the
// sync bytes, its third byte is node_id or zero and its 8-bit sum is zero.
// The match is decided in the cycle the completing byte is accepted; the
// frame is copied into a second chain of output cells and its first byte
// appears in the next cycle. The burst then moves one byte per frame item.
// Throughput: one rx item per cycle while rx is ready. A match clears the
// window, so the next match needs PACKET_LEN more bytes, the burst length.
// When the receiver stalls, rx keeps flowing until the window holds
// PACKET_LEN-1 bytes; then rx.ready drops until the burst is drained or its
// last byte leaves in that cycle.
// Reset clears the registers, the window, its sum and fill count, and
// empties the output buffer.
module header_checksum_frame_finder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	hcff_rx_if.sink                       rx,
	hcff_frame_if.source                  frame,
	input  logic                          cfg_wr_en,
	input  logic [hcff_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hcff_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int N = hcff_pkg::PACKET_LEN;

	// Configuration registers
	hcff_pkg::byte_t sync_first_q;
	hcff_pkg::byte_t sync_second_q;
	hcff_pkg::byte_t node_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= '0;
			sync_second_q <= '0;
			node_id_q     <= '0;
		end else if (cfg_wr_en) begin
			case (hcff_pkg::cfg_idx_t'(cfg_index))
				hcff_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata;
				hcff_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_wdata;
				hcff_pkg::CFG_NODE_ID:     node_id_q     <= cfg_wdata;
				default: ; // drop writes to unknown indexes
			endcase
		end
	end

	// Window chain: cell 0 holds the oldest byte, new bytes enter at N-1.
	hcff_pkg::byte_t   win_q [N];
	hcff_pkg::byte_t   win_d [N];
	hcff_pkg::win_ctrl_t win_ctrl;

	hcff_pkg::byte_t   sum_q;
	hcff_pkg::byte_t   sum_next;
	hcff_pkg::cnt_t    fill_q;
	hcff_pkg::cnt_t    out_cnt_q;

	logic in_fire;
	logic out_fire;
	logic busy;
	logic last_leaving;
	logic near_full;
	logic hit;

	// Output buffer chain: cell 0 is the head shown on the frame channel.
	hcff_pkg::byte_t   out_q [N];
	hcff_pkg::byte_t   out_shift_d [N];
	hcff_pkg::out_ctrl_t out_ctrl;

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cells
			if (gi == N - 1) begin : g_tail
				assign win_d[gi]       = rx.rx_byte;
				assign out_shift_d[gi] = '0;
			end else begin : g_body
				assign win_d[gi]       = win_q[gi+1];
				assign out_shift_d[gi] = out_q[gi+1];
			end

			hcff_win_cell u_win (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (win_ctrl),
				.d      (win_d[gi]),
				.q      (win_q[gi])
			);

			// The frame loaded is the window after this shift.
			hcff_out_cell u_out (
				.clk     (clk),
				.ctrl    (out_ctrl),
				.load_d  (win_d[gi]),
				.shift_d (out_shift_d[gi]),
				.q       (out_q[gi])
			);
		end
	endgenerate

	assign busy         = (out_cnt_q != '0);
	assign out_fire     = frame.valid && frame.ready;
	assign last_leaving = out_fire && frame.frame_last;
	assign near_full    = (fill_q >= hcff_pkg::CNT_W'(N - 1));

	// Hold rx only when the next byte could complete a frame while the
	// buffer still holds one that is not leaving now.
	assign rx.ready = !(near_full && busy && !last_leaving);
	assign in_fire  = rx.valid && rx.ready;

	// The oldest byte drops out as the new one enters; cleared cells are
	// zero, so this holds while the window is still filling too.
	assign sum_next = sum_q - win_q[0] + rx.rx_byte;

	// Compare the window as it stands after the shift.
	assign hit = near_full
		&& (win_q[1] == sync_first_q)
		&& (win_q[2] == sync_second_q)
		&& ((win_q[3] == node_id_q) || (win_q[3] == '0))
		&& (sum_next == '0);

	assign win_ctrl.shift = in_fire;
	assign win_ctrl.clear = in_fire && hit;

	assign out_ctrl.load  = in_fire && hit;
	assign out_ctrl.shift = out_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			fill_q <= '0;
		end else if (in_fire) begin
			if (hit) begin
				sum_q  <= '0;
				fill_q <= '0;
			end else begin
				sum_q <= sum_next;
				if (!(fill_q == hcff_pkg::CNT_W'(N))) begin
					fill_q <= fill_q + hcff_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (in_fire && hit) begin
			out_cnt_q <= hcff_pkg::CNT_W'(N);
		end else if (out_fire) begin
			out_cnt_q <= out_cnt_q - hcff_pkg::CNT_W'(1);
		end
	end

	assign frame.valid      = busy;
	assign frame.frame_byte = out_q[0];
	assign frame.frame_last = (out_cnt_q == hcff_pkg::CNT_W'(1));

`ifndef NO_ASSERTIONS
	// A match never overwrites a burst that is still being delivered.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && hit) |-> (!busy || last_leaving))
		else $error("frame matched while output buffer still busy");

	// A match empties the window.
	a_clear_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && hit) |=> (fill_q == '0 && sum_q == '0))
		else $error("window not cleared after a match");

	// An empty window has a zero sum.
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (sum_q == '0))
		else $error("window sum nonzero with empty window");

	// A matched frame starts delivery in the next cycle with a full count.
	a_burst_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && hit) |=> (frame.valid && out_cnt_q == hcff_pkg::CNT_W'(N)))
		else $error("frame burst did not start after a match");
`endif

endmodule

@@ rtl/hcff_win_cell.sv @@
// One byte cell of the sliding receive window.
module hcff_win_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  hcff_pkg::win_ctrl_t ctrl,
	input  hcff_pkg::byte_t     d,
	output hcff_pkg::byte_t     q
);

	hcff_pkg::byte_t byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctrl.clear) begin
			byte_q <= '0;
		end else if (ctrl.shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

@@ rtl/hcff_out_cell.sv @@
// One byte cell of the frame output buffer.
module hcff_out_cell (
	input  logic                clk,
	input  hcff_pkg::out_ctrl_t ctrl,
	input  hcff_pkg::byte_t     load_d,
	input  hcff_pkg::byte_t     shift_d,
	output hcff_pkg::byte_t     q
);

	hcff_pkg::byte_t byte_q;

	// Load wins over shift: a new frame replaces the departing last byte.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= load_d;
		end else if (ctrl.shift) begin
			byte_q <= shift_d;
		end
	end

	assign q = byte_q;

endmodule

@@ tb/tb_top.sv @@
// Testbench of the header checksum frame finder: directed table, random frames, predictor.
`timescale 1ns / 100ps

module tb_top;

	// Register index with no register behind it; writes to it must be dropped.
	localparam logic [hcff_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam int IDLE_PCT       = 35;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = hcff_pkg::PACKET_LEN + 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_COUNT    = 5;
	localparam int PHASE_BYTES    = 12;
	localparam int CALM_PHASE     = 3;
	localparam int PRESSURE_PHASE = 4;
	localparam int DIR_ROWS       = 25;

	typedef struct {
		hcff_pkg::byte_t data;
		logic            last;
	} frame_item_t;

	// One directed row: the byte to send and, where it is obvious, whether
	// this byte completes a frame made of copies of itself.
	typedef struct {
		hcff_pkg::byte_t data;
		bit              typed;
		bit              hit;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [hcff_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [hcff_pkg::CFG_DATA_W-1:0] cfg_wdata;

	hcff_rx_if    rx_if();
	hcff_frame_if fr_if();

	header_checksum_frame_finder_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.frame     (fr_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Mirror of the registers and the sliding window of received bytes.
	hcff_pkg::byte_t sync_first_r;
	hcff_pkg::byte_t sync_second_r;
	hcff_pkg::byte_t node_id_r;
	hcff_pkg::byte_t win [hcff_pkg::PACKET_LEN];
	int unsigned     win_fill;
	hcff_pkg::byte_t win_sum;

	frame_item_t frame_q[$];
	dir_row_t    dir_rows [DIR_ROWS];

	int unsigned errors;
	int unsigned phase_bytes;
	int unsigned quiet_cycles;
	bit          calm;
	bit          hold_req;

	always #2 clk = ~clk;

	// Slide one received byte into the window; on a match queue the whole
	// window as frame items (unless told not to) and clear it.
	function automatic bit predict_rx_byte(input hcff_pkg::byte_t b, input bit emit);
		int  k;
		bit  found;
		if (win_fill < hcff_pkg::PACKET_LEN) begin
			win[win_fill] = b;
			win_fill++;
		end else begin
			win_sum = win_sum - win[0];
			for (k = 0; k < hcff_pkg::PACKET_LEN - 1; k++)
				win[k] = win[k + 1];
			win[hcff_pkg::PACKET_LEN - 1] = b;
		end
		win_sum = win_sum + b;
		found = win_fill == hcff_pkg::PACKET_LEN && win[0] == sync_first_r &&
			win[1] == sync_second_r && (win[2] == node_id_r || win[2] == 8'h00) &&
			win_sum == 8'h00;
		if (found) begin
			for (k = 0; k < hcff_pkg::PACKET_LEN; k++) begin
				if (emit)
					frame_q.push_back('{data: win[k],
						last: k == hcff_pkg::PACKET_LEN - 1});
				win[k] = 8'h00;
			end
			win_fill = 0;
			win_sum  = 8'h00;
		end
		return found;
	endfunction

	// Offer one byte and hold it until the block takes it. Valid stays high
	// from one item to the next unless a random gap is inserted.
	task automatic send_byte(input hcff_pkg::byte_t b);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			rx_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
	endtask

	task automatic feed_byte(input hcff_pkg::byte_t b);
		send_byte(b);
		void'(predict_rx_byte(b, 1'b1));
		phase_bytes++;
	endtask

	// Build a frame for the current registers: sync bytes, an address that is
	// mostly ours or broadcast, random payload and a closing checksum byte.
	// A broken frame has one bit flipped somewhere.
	task automatic send_frame(input bit broken);
		hcff_pkg::byte_t f [hcff_pkg::PACKET_LEN];
		hcff_pkg::byte_t s;
		int              k;
		f[0] = sync_first_r;
		f[1] = sync_second_r;
		case ($urandom_range(3))
			0: begin
				f[2] = 8'h00;
			end
			1: begin
				f[2] = hcff_pkg::byte_t'($urandom_range(255));
			end
			default: begin
				f[2] = node_id_r;
			end
		endcase
		for (k = 3; k < hcff_pkg::PACKET_LEN - 1; k++)
			f[k] = hcff_pkg::byte_t'($urandom_range(255));
		s = 8'h00;
		for (k = 0; k < hcff_pkg::PACKET_LEN - 1; k++)
			s = s + f[k];
		f[hcff_pkg::PACKET_LEN - 1] = -s;
		if (broken)
			f[$urandom_range(hcff_pkg::PACKET_LEN - 1)] ^= 8'h01 << $urandom_range(7);
		for (k = 0; k < hcff_pkg::PACKET_LEN; k++)
			feed_byte(f[k]);
	endtask

	// Stop offering, wait until every expected frame item is out, then give
	// the block its full latency before anything else happens.
	task automatic settle();
		rx_if.valid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all registers back to back, optionally also the unused index,
	// and drop the enable once at the end.
	task automatic write_regs(input hcff_pkg::byte_t s1, input hcff_pkg::byte_t s2,
		input hcff_pkg::byte_t nid, input bit spare);
		cfg_wr_en <= 1'b1;
		cfg_index <= hcff_pkg::CFG_SYNC_FIRST;
		cfg_wdata <= s1;
		@(posedge clk);
		cfg_index <= hcff_pkg::CFG_SYNC_SECOND;
		cfg_wdata <= s2;
		@(posedge clk);
		cfg_index <= hcff_pkg::CFG_NODE_ID;
		cfg_wdata <= nid;
		@(posedge clk);
		if (spare) begin
			cfg_index <= CFG_SPARE;
			cfg_wdata <= hcff_pkg::CFG_DATA_W'($urandom_range(255));
			@(posedge clk);
		end
		cfg_wr_en     <= 1'b0;
		sync_first_r  = s1;
		sync_second_r = s2;
		node_id_r     = nid;
	endtask

	// Check every frame item taken by the receiver against the oldest one
	// still expected.
	always @(posedge clk) begin
		if (arst_n && fr_if.valid && fr_if.ready) begin
			if (frame_q.size() == 0) begin
				$display("%0t: unexpected frame item: byte %02h last %0b, none expected",
					$time, fr_if.frame_byte, fr_if.frame_last);
				errors++;
			end else begin
				if (fr_if.frame_byte !== frame_q[0].data ||
					fr_if.frame_last !== frame_q[0].last) begin
					$display("%0t: frame item mismatch: expected %02h/%0b, got %02h/%0b",
						$time, frame_q[0].data, frame_q[0].last,
						fr_if.frame_byte, fr_if.frame_last);
					errors++;
				end
				void'(frame_q.pop_front());
			end
		end
	end

	// End the run if nothing moves on any port for too long.
	always @(posedge clk) begin
		if ((rx_if.valid && rx_if.ready) || (fr_if.valid && fr_if.ready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, none while calm, and one long hold-off on
	// request so the burst backs up into the input.
	initial begin
		fr_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				fr_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			fr_if.ready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	initial begin
		int i;
		int p;
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = hcff_pkg::CFG_SYNC_FIRST;
		cfg_wdata     = 8'h00;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = 8'h00;
		errors        = 0;
		quiet_cycles  = 0;
		calm          = 1'b0;
		hold_req      = 1'b0;
		sync_first_r  = 8'h00;
		sync_second_r = 8'h00;
		node_id_r     = 8'h00;
		win_fill      = 0;
		win_sum       = 8'h00;
		foreach (win[i])
			win[i] = 8'h00;

		// Directed table. With all registers at their reset value, sixteen
		// zeros form a valid frame: nothing comes out while the window fills,
		// the sixteenth zero releases a frame of zeros. The window is then
		// empty again, so the run of all-ones bytes cannot match. The last
		// few rows are left to the predictor.
		for (i = 0; i < hcff_pkg::PACKET_LEN; i++)
			dir_rows[i] = '{data: 8'h00, typed: 1'b1, hit: i == hcff_pkg::PACKET_LEN - 1};
		for (i = hcff_pkg::PACKET_LEN; i < hcff_pkg::PACKET_LEN + 6; i++)
			dir_rows[i] = '{data: 8'hFF, typed: 1'b1, hit: 1'b0};
		dir_rows[hcff_pkg::PACKET_LEN + 6] = '{data: 8'h80, typed: 1'b0, hit: 1'b0};
		dir_rows[hcff_pkg::PACKET_LEN + 7] = '{data: 8'h01, typed: 1'b0, hit: 1'b0};
		dir_rows[hcff_pkg::PACKET_LEN + 8] = '{data: 8'h7F, typed: 1'b0, hit: 1'b0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].data);
			void'(predict_rx_byte(dir_rows[i].data, !dir_rows[i].typed));
			if (dir_rows[i].typed && dir_rows[i].hit)
				for (p = 0; p < hcff_pkg::PACKET_LEN; p++)
					frame_q.push_back('{data: dir_rows[i].data,
						last: p == hcff_pkg::PACKET_LEN - 1});
		end
		settle();

		// Random phases: all-ones and all-zeros registers, then random
		// settings. Mostly well-formed frames, some broken, some noise bytes
		// that shift the window between them.
		for (p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin
					write_regs(8'hFF, 8'hFF, 8'hFF, 1'b0);
				end
				1: begin
					write_regs(8'h00, 8'h00, 8'h00, 1'b1);
				end
				default: begin
					write_regs(hcff_pkg::byte_t'($urandom_range(255)),
						hcff_pkg::byte_t'($urandom_range(255)),
						hcff_pkg::byte_t'($urandom_range(255)), p == 2);
				end
			endcase
			calm        = p == CALM_PHASE;
			phase_bytes = 0;
			if (p == PRESSURE_PHASE) begin
				// Hold the receiver off and keep offering good frames so the
				// output backs up and the input stalls.
				hold_req = 1'b1;
				send_frame(1'b0);
				send_frame(1'b0);
			end
			while (phase_bytes < PHASE_BYTES) begin
				if ($urandom_range(99) < 75) begin
					send_frame($urandom_range(99) < 20);
				end else begin
					repeat ($urandom_range(4, 1))
						feed_byte(hcff_pkg::byte_t'($urandom_range(255)));
				end
			end
			settle();
		end
		calm = 1'b0;

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
